@@ rtl/chti_pkg.sv @@
`default_nettype none
package chti_pkg;
    localparam logic [63:0] FNV_BASIS = 64'd2166136261;
    localparam logic [63:0] FNV_PRIME = 64'd16777619;

    // node pool size; the entry count width CNT_W is derived from it
    localparam int POOL_NODES = 1024;
    localparam int NODE_W     = $clog2(POOL_NODES);
    localparam int CNT_W      = $clog2(POOL_NODES + 1);

    localparam logic [1:0] ST_NEW     = 2'd0;
    localparam logic [1:0] ST_UPDATED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [0:0] CFG_KEY_BYTES    = 1'b0;
    localparam logic [0:0] CFG_BUCKET_COUNT = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture key and value, start hash
        logic hash_step;  // fold one key byte
        logic mod_start;  // start the bucket remainder
        logic mod_step;   // one remainder bit
        logic head_rd;    // read bucket head
        logic node_rd;    // read node at cursor
        logic follow;     // move cursor to link
        logic upd_val;    // overwrite value at cursor
        logic app_head;   // new node, hook on bucket head
        logic app_link;   // new node, hook on cursor link
    } chti_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic hash_last;
        logic mod_done;
        logic head_valid;
        logic key_match;
        logic link_valid;
        logic pool_full;
        logic walk_limit;
    } chti_sts_t;
endpackage
`default_nettype wire

@@ rtl/chti_datapath.sv @@
`default_nettype none
module chti_datapath #(
    parameter int MAX_BUCKETS = 256,
    parameter int VALUE_BYTES = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire chti_pkg::chti_cmd_t cmd,
    output chti_pkg::chti_sts_t    sts,
    input  wire logic [63:0]       key,
    input  wire logic [63:0]       value,
    input  wire logic [3:0]        key_bytes,
    input  wire logic [8:0]        bucket_count,
    output logic [chti_pkg::CNT_W-1:0] count
);
    import chti_pkg::*;

    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int NW = NODE_W;
    localparam int CW = CNT_W;
    localparam int DW = 9;
    localparam int VB = VALUE_BYTES * 8;

    logic [63:0] key_reg, val_reg, hash_reg, kmask_reg;
    logic [2:0]  byte_reg;
    logic [3:0]  nb_reg;
    logic [DW-1:0] div_reg, rem_reg;
    logic [6:0]  mbit_reg;
    logic [NW-1:0] cur_reg;
    logic [CW-1:0] count_reg, steps_reg;

    // bucket heads with valid bits
    logic [NW-1:0] heads [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0] hvalid_reg;
    logic          head_v_reg;

    // node pool; links always point past node zero, so a zero link marks the tail
    logic [63:0]   nkeys  [POOL_NODES];
    logic [VB-1:0] nvals  [POOL_NODES];
    logic [NW-1:0] nlinks [POOL_NODES];
    logic [63:0]   nkey_rd_reg;
    logic [NW-1:0] nlink_rd_reg;

    logic [BW-1:0] bucket;
    logic [NW-1:0] fresh;
    logic [DW:0]   trial;
    logic [63:0]   hx;

    assign bucket = BW'(rem_reg);
    assign fresh  = NW'(count_reg);
    assign count  = count_reg;
    assign hx     = hash_reg ^ {56'd0, key_reg[{byte_reg, 3'd0} +: 8]};
    assign trial  = {rem_reg, hash_reg[mbit_reg[5:0]]} - {1'b0, div_reg};

    assign sts.hash_last  = ({1'b0, byte_reg} + 4'd1) >= nb_reg;
    assign sts.mod_done   = mbit_reg[6];
    assign sts.head_valid = head_v_reg;
    assign sts.key_match  = ((nkey_rd_reg ^ key_reg) & kmask_reg) == 64'd0;
    assign sts.link_valid = nlink_rd_reg != '0;
    assign sts.pool_full  = count_reg >= CW'(POOL_NODES);
    assign sts.walk_limit = steps_reg + CW'(1) >= CW'(POOL_NODES);

    // key and value capture, hash, remainder, cursor and node read registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= key;
            val_reg  <= value;
            hash_reg <= FNV_BASIS;
            byte_reg <= 3'd0;
            nb_reg   <= (key_bytes == 4'd0) ? 4'd1 : (key_bytes > 4'd8) ? 4'd8 : key_bytes;
            div_reg  <= (bucket_count == 9'd0) ? 9'd1
                      : (32'(bucket_count) > MAX_BUCKETS) ? DW'(MAX_BUCKETS) : bucket_count;
        end
        if (cmd.hash_step)
        begin
            hash_reg <= hx * FNV_PRIME;
            byte_reg <= byte_reg + 3'd1;
        end
        if (cmd.mod_start)
        begin
            kmask_reg <= (nb_reg >= 4'd8) ? '1 : ((64'd1 << {nb_reg[2:0], 3'd0}) - 64'd1);
            rem_reg   <= '0;
            mbit_reg  <= 7'd63;
        end
        // restoring remainder, one bit a cycle, msb first
        if (cmd.mod_step)
        begin
            if (!trial[DW])
                rem_reg <= trial[DW-1:0];
            else
                rem_reg <= {rem_reg[DW-2:0], hash_reg[mbit_reg[5:0]]};
            mbit_reg <= mbit_reg - 7'd1;
        end
        if (cmd.head_rd)
        begin
            head_v_reg  <= hvalid_reg[bucket];
            cur_reg     <= heads[bucket];
            steps_reg   <= '0;
        end
        if (cmd.node_rd)
        begin
            nkey_rd_reg  <= nkeys[cur_reg];
            nlink_rd_reg <= nlinks[cur_reg];
        end
        if (cmd.follow)
        begin
            cur_reg   <= nlink_rd_reg;
            steps_reg <= steps_reg + CW'(1);
        end
    end

    // memory writes
    always_ff @(posedge clk)
    begin
        if (cmd.upd_val)
            nvals[cur_reg] <= val_reg[VB-1:0];
        if (cmd.app_head || cmd.app_link)
        begin
            nkeys[fresh] <= key_reg;
            nvals[fresh] <= val_reg[VB-1:0];
        end
        if (cmd.app_head)
            heads[bucket] <= fresh;
        // hook the new node on the tail, or mark the next free node as a tail early
        if (cmd.app_link)
            nlinks[cur_reg] <= fresh;
        else if (cmd.head_rd && !sts.pool_full)
            nlinks[fresh] <= '0;
    end

    // head valid bits and entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hvalid_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cmd.app_head)
                hvalid_reg[bucket] <= 1'b1;
            if (cmd.app_head || cmd.app_link)
                count_reg <= count_reg + CW'(1);
        end
    end
endmodule
`default_nettype wire

@@ rtl/chti_ctrl.sv @@
`default_nettype none
module chti_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             status,
    output chti_pkg::chti_cmd_t    cmd,
    input  wire chti_pkg::chti_sts_t sts
);
    import chti_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_HASH  = 8'b00000010,
        S_MOD   = 8'b00000100,
        S_HEAD  = 8'b00001000,
        S_HCHK  = 8'b00010000,
        S_NODE  = 8'b00100000,
        S_NCHK  = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] status_reg, status_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign status    = status_reg;

    // next state, status and commands
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (sts.hash_last)
                    state_next = S_MOD;
            end
            S_MOD:
            begin
                if (!cmd.mod_step && !sts.mod_done)
                    cmd.mod_step = 1'b1;
                if (sts.mod_done)
                    state_next = S_HEAD;
            end
            S_HEAD:
            begin
                cmd.head_rd = 1'b1;
                state_next  = S_HCHK;
            end
            S_HCHK:
                if (!sts.head_valid)
                begin
                    if (sts.pool_full)
                        status_next = ST_FULL;
                    else
                    begin
                        cmd.app_head = 1'b1;
                        status_next  = ST_NEW;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.node_rd = 1'b1;
                    state_next  = S_NCHK;
                end
            S_NODE:
            begin
                cmd.node_rd = 1'b1;
                state_next  = S_NCHK;
            end
            S_NCHK:
            begin
                if (sts.key_match)
                begin
                    cmd.upd_val = 1'b1;
                    status_next = ST_UPDATED;
                    state_next  = S_DONE;
                end
                else if (!sts.link_valid || sts.walk_limit)
                begin
                    if (sts.pool_full)
                        status_next = ST_FULL;
                    else
                    begin
                        cmd.app_link = 1'b1;
                        status_next  = ST_NEW;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.follow = 1'b1;
                    state_next = S_NODE;
                end
            end
            S_DONE:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
        if (state_reg == S_HASH && sts.hash_last)
            cmd.mod_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_NEW;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/chained_hash_table_insert.sv @@
// an insert hashes the key bytes, forms the bucket remainder bit-serially, reads the bucket
//          head, then walks the chain until a key match, the tail or the walk limit
// one insert at a time; the next accept waits until out_valid has been taken by out_ready
// the bit-serial bucket remainder and the node walk set the time an insert takes
// reset: bucket heads empty, entry count zero, key_bytes 8, bucket_count 256
`default_nettype none
module chained_hash_table_insert #(
    parameter int MAX_BUCKETS = 256,
    parameter int VALUE_BYTES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] key,
    input  wire logic [63:0] value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [10:0]      entry_count
);
    import chti_pkg::*;

    chti_cmd_t cmd;
    chti_sts_t sts;
    logic [3:0] key_bytes_reg;
    logic [8:0] bucket_count_reg;
    logic [CNT_W-1:0] count;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg    <= 4'd8;
            bucket_count_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_BYTES:    key_bytes_reg    <= cfg_data[3:0];
                CFG_BUCKET_COUNT: bucket_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign entry_count = 11'(count);

    chti_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .cmd(cmd), .sts(sts)
    );

    chti_datapath #(
        .MAX_BUCKETS(MAX_BUCKETS), .VALUE_BYTES(VALUE_BYTES)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .key(key), .value(value),
        .key_bytes(key_bytes_reg), .bucket_count(bucket_count_reg),
        .count(count)
    );
endmodule
`default_nettype wire

@@ rtl/chti_checker.sv @@
`default_nettype none
module chti_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic [10:0] entry_count
);
    import chti_pkg::*;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_NEW || status == ST_UPDATED || status == ST_FULL))
        else $error("bad status code");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)) else $error("result dropped");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("accept while result pending");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (status == ST_NEW) == (entry_count == $past(entry_count) + 11'd1))
        else $error("entry count mismatch");
endmodule

bind chained_hash_table_insert chti_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .entry_count(entry_count)
);
`default_nettype wire
